/* hw/rtl/mf3_pkg.sv */
// Shared types, constants and the helper function of the 3x3 median filter.
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][PIX_W-1:0] pix3_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic op;
    pix_t pixel_in;
  } mf3_in_t;

  typedef struct packed {
    pix_t pixel_out;
    logic end_of_frame;
  } mf3_out_t;

  // One window snapshot on its way from the front to the median unit.
  typedef struct packed {
    win_t win;
    logic interior;
    logic eof;
  } mf3_win_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } q_stat_t;

  // Sorts three pixels ascending: element 0 is the smallest.
  function automatic pix3_t sort3(input pix3_t v);
    pix3_t s;
    pix_t  t;
    s = v;
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    if (s[1] > s[2]) begin
      t = s[1]; s[1] = s[2]; s[2] = t;
    end
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    return s;
  endfunction

endpackage

/* hw/rtl/mf3_front.sv */
// Front end: configuration, position counters, line stores and the 3x3 window.
module mf3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mf3_pkg::mf3_in_t              in_data,
  input  mf3_pkg::q_stat_t              q_stat,
  output logic                          q_push,
  output mf3_pkg::mf3_win_t             q_wdata
);
  import mf3_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > FW_W) ? WW : FW_W;

  logic [FW_W-1:0] frame_width_r, frame_width_nxt;
  logic [FH_W-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]   fw_ext, eff_w;
  logic [FH_W-1:0] eff_h;

  logic [CB-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [FH_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic accept, drain_phase, take, emit, interior, eof, cfg_hit;
  logic in_wrap, out_wrap;
  pix_t px;

  pix_t upper_mem_r [MAX_WIDTH];
  pix_t lower_mem_r [MAX_WIDTH];
  pix_t rd_up_r, rd_lo_r;

  logic          s2_valid_r, s2_emit_r, s2_interior_r, s2_eof_r;
  logic [CB-1:0] s2_col_r;
  pix_t          s2_px_r;

  win_t win_r, win_nxt;

  // Effective frame size: width clamped to 3..MAX_WIDTH, height to at least 3.
  always_comb begin
    fw_ext = CW'(frame_width_r);
    eff_w  = fw_ext;
    if (fw_ext < CW'(MIN_DIM)) begin
      eff_w = CW'(MIN_DIM);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end
    eff_h = (frame_height_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_r;
  end

  // Room is checked against the queue plus the item now in the second stage.
  assign in_stall = (q_stat.count + QCNT_W'(s2_valid_r)) >= QCNT_W'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  assign drain_phase = in_row_r >= eff_h;
  // A drain item that arrives before the last pixel is dropped without effect.
  assign take     = accept && !(in_data.op == OP_DRAIN && !drain_phase);
  assign px       = drain_phase ? '0 : in_data.pixel_in;
  assign emit     = (in_row_r >= FH_W'(2)) || (in_row_r == FH_W'(1) && in_col_r != '0);
  assign interior = (out_row_r != '0) && ((out_row_r + FH_W'(1)) < eff_h) &&
                    (out_col_r != '0) && ((CW'(out_col_r) + CW'(1)) < eff_w);
  assign eof      = emit && ((out_row_r + FH_W'(1)) >= eff_h) &&
                    ((CW'(out_col_r) + CW'(1)) >= eff_w);
  assign in_wrap  = (CW'(in_col_r) + CW'(1)) >= eff_w;
  assign out_wrap = (CW'(out_col_r) + CW'(1)) >= eff_w;
  assign cfg_hit  = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
      frame_width_nxt = cfg_wdata[FW_W-1:0];
    end
    if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
      frame_height_nxt = cfg_wdata[FH_W-1:0];
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (eof) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (in_wrap) begin
          in_col_nxt = '0;
          if (in_row_r < eff_h) begin
            in_row_nxt = in_row_r + FH_W'(1);
          end
        end else begin
          in_col_nxt = in_col_r + CB'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col_nxt = '0;
            if (out_row_r < eff_h) begin
              out_row_nxt = out_row_r + FH_W'(1);
            end
          end else begin
            out_col_nxt = out_col_r + CB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      s2_valid_r     <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      s2_valid_r     <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_col_r      <= in_col_r;
      s2_px_r       <= px;
      s2_emit_r     <= emit;
      s2_interior_r <= interior;
      s2_eof_r      <= eof;
    end
  end

  // The column is read when an item is taken and written back in the next cycle;
  // a column comes round again only after a full row of at least three items.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_up_r <= upper_mem_r[in_col_r];
      rd_lo_r <= lower_mem_r[in_col_r];
    end
    if (s2_valid_r) begin
      upper_mem_r[s2_col_r] <= rd_lo_r;
      lower_mem_r[s2_col_r] <= s2_px_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[3*r]     = win_r[3*r + 1];
      win_nxt[3*r + 1] = win_r[3*r + 2];
    end
    win_nxt[2] = rd_up_r;
    win_nxt[5] = rd_lo_r;
    win_nxt[8] = s2_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s2_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign q_push           = s2_valid_r && s2_emit_r;
  assign q_wdata.win      = win_nxt;
  assign q_wdata.interior = s2_interior_r;
  assign q_wdata.eof      = s2_eof_r;

endmodule

/* hw/rtl/mf3_queue.sv */
// Small queue of window snapshots between the front end and the median unit.
module mf3_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mf3_pkg::mf3_win_t wdata,
  input  logic              pop,
  output mf3_pkg::mf3_win_t rdata,
  output mf3_pkg::q_stat_t  q_stat
);
  import mf3_pkg::*;

  mf3_win_t            entries_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata            = entries_r[rd_ptr_r];
  assign q_stat.count     = count_r;
  assign q_stat.not_empty = count_r != '0;

endmodule

/* hw/rtl/mf3_back.sv */
// Back end: three-stage median-of-nine pipeline ending in the output register.
module mf3_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mf3_pkg::q_stat_t  q_stat,
  input  mf3_pkg::mf3_win_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mf3_pkg::mf3_out_t out_data
);
  import mf3_pkg::*;

  logic adv;

  logic  a_valid_r, a_int_r, a_eof_r;
  pix3_t a_rows_r [3];
  pix_t  a_center_r;

  logic  b_valid_r, b_int_r, b_eof_r;
  pix3_t b_trio_r, b_trio_nxt;
  pix_t  b_center_r;

  logic     out_valid_r;
  mf3_out_t out_data_r, out_data_nxt;

  pix3_t lows, mids, highs, lo_s, mid_s, hi_s, fin_s;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_stat.not_empty;

  // Median of nine: sort each row, then the median of the largest low,
  // the median middle and the smallest high; border pixels keep the center.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lows[r]  = a_rows_r[r][0];
      mids[r]  = a_rows_r[r][1];
      highs[r] = a_rows_r[r][2];
    end
    lo_s  = sort3(lows);
    mid_s = sort3(mids);
    hi_s  = sort3(highs);
    b_trio_nxt[0] = lo_s[2];
    b_trio_nxt[1] = mid_s[1];
    b_trio_nxt[2] = hi_s[0];
    fin_s = sort3(b_trio_r);
    out_data_nxt.pixel_out    = b_int_r ? fin_s[1] : b_center_r;
    out_data_nxt.end_of_frame = b_eof_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_pop;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        a_rows_r[r] <= sort3({q_rdata.win[3*r + 2], q_rdata.win[3*r + 1], q_rdata.win[3*r]});
      end
      a_center_r <= q_rdata.win[4];
      a_int_r    <= q_rdata.interior;
      a_eof_r    <= q_rdata.eof;
      b_trio_r   <= b_trio_nxt;
      b_center_r <= a_center_r;
      b_int_r    <= a_int_r;
      b_eof_r    <= a_eof_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/median_filter_3x3.sv */
// Top level of the streaming 3x3 median filter for 8-bit gray frames.
//
// Pixels enter on the in_ channel in raster order (op = pixel). After the
// last pixel of a frame the host sends frame_width + 1 drain items to push
// out the final row; a drain item sent earlier is taken and dropped.
// Results leave on the out_ channel in raster order: interior pixels are the
// median of their 3x3 neighborhood, border pixels pass through unchanged,
// and end_of_frame marks the last pixel of the frame.
// frame_width and frame_height are written on the cfg_ port; the user must
// write them only while the block is idle, which the block does not enforce;
// a write restarts the frame position. Throughput is one item per cycle
// while in_stall is low. A result is shown once the item that completes
// its neighborhood has passed the line store read and the window update
// into the queue, and then the median pipeline (row sort, column select,
// final pick and output register). When the receiver stalls, the output
// and the median pipeline hold, the four-entry queue fills, and in_stall
// rises once the queue and the window stage together hold four items.
// Reset clears the counters, the window and all valid flags; the line stores
// are not cleared and need no clearing pass.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mf3_pkg::mf3_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mf3_pkg::mf3_out_t             out_data
);
  import mf3_pkg::*;

  logic     q_push, q_pop;
  mf3_win_t q_wdata, q_rdata;
  q_stat_t  q_stat;

  mf3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mf3_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .q_stat(q_stat)
  );

  mf3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/mf3_checker.sv */
// Port-level checks of the median filter and their binding to the top level.
module mf3_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mf3_pkg::mf3_out_t out_data
);

  // A stalled result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the queue and the front pipeline, so input is taken at once.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
